// ===== src/ptc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the pressure and temperature compensation core.
package ptc_pkg;

    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CAL_A = 3'd0,
        CFG_CAL_B = 3'd1,
        CFG_CAL_C = 3'd2,
        CFG_CAL_D = 3'd3,
        CFG_OSS   = 3'd4
    } cfg_index_t;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] P_COEF_SQ  = 32'd3038;
    localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343;
    localparam logic [31:0] P_COEF_OFS = 32'd3791;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] HALF_SCALE = 32'd32768;

    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } cal_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        logic [31:0] r;
        r = $signed(v) >>> n;
        return r;
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

endpackage

// ===== src/pressure_temperature_compensation_core.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
// Throughput: one item per cycle unless the output stalls; two chained 32-stage dividers set the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears calibration registers and all valid bits; payload is not reset.
module pressure_temperature_compensation_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [47:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_raw_temperature,
    input  logic [23:0]                   s_raw_pressure,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_temperature,
    output logic signed [31:0]            m_pressure,
    output logic                          m_divide_error
);
    logic [47:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg, cal_d_reg;
    logic [1:0]  oss_reg;
    ptc_pkg::cal_t cal;
    logic en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            cal_d_reg <= '0;
            oss_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ptc_pkg::CFG_CAL_A: cal_a_reg <= cfg_data;
                ptc_pkg::CFG_CAL_B: cal_b_reg <= cfg_data;
                ptc_pkg::CFG_CAL_C: cal_c_reg <= cfg_data[31:0];
                ptc_pkg::CFG_CAL_D: cal_d_reg <= cfg_data[31:0];
                ptc_pkg::CFG_OSS:   oss_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.ac1 = ptc_pkg::sx16(cal_a_reg[47:32]);
        cal.ac2 = ptc_pkg::sx16(cal_a_reg[31:16]);
        cal.ac3 = ptc_pkg::sx16(cal_a_reg[15:0]);
        cal.ac4 = {16'd0, cal_b_reg[47:32]};
        cal.ac5 = {16'd0, cal_b_reg[31:16]};
        cal.ac6 = {16'd0, cal_b_reg[15:0]};
        cal.b1  = ptc_pkg::sx16(cal_c_reg[31:16]);
        cal.b2  = ptc_pkg::sx16(cal_c_reg[15:0]);
        cal.mc  = ptc_pkg::sx16(cal_d_reg[31:16]);
        cal.md  = ptc_pkg::sx16(cal_d_reg[15:0]);
        cal.oss = oss_reg;
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage A: difference and product for X1, and the shifted raw pressure.
    logic        a_v_reg;
    logic [31:0] a_prod_reg, a_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) a_v_reg <= 1'b0;
        else if (en) a_v_reg <= s_valid;
        if (en) begin
            a_prod_reg <= ptc_pkg::mul32({16'd0, s_raw_temperature} - cal.ac6, cal.ac5);
            a_up_reg   <= {8'd0, s_raw_pressure} >> (4'd8 - {2'd0, cal.oss});
        end
    end

    // Stage B: X1, denominator and signed operand magnitudes for X2.
    logic        b_v_reg, b_err_reg, b_neg_reg;
    logic [31:0] b_x1_reg, b_up_reg, b_num_reg, b_den_reg;
    logic [31:0] x1b, denb, numb;
    always_comb begin
        x1b  = ptc_pkg::asr(a_prod_reg, 5'd15);
        denb = x1b + cal.md;
        numb = cal.mc << 11;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) b_v_reg <= 1'b0;
        else if (en) b_v_reg <= a_v_reg;
        if (en) begin
            b_x1_reg  <= x1b;
            b_up_reg  <= a_up_reg;
            b_err_reg <= (denb == '0);
            b_neg_reg <= numb[31] ^ denb[31];
            b_num_reg <= numb[31] ? -numb : numb;
            b_den_reg <= (denb == '0) ? 32'd1 : (denb[31] ? -denb : denb);
        end
    end

    localparam int unsigned S1W = 32 + 32 + 1 + 1;
    logic           d1_v;
    logic [31:0]    d1_q;
    logic [S1W-1:0] d1_side;
    ptc_udiv #(.SideW(S1W)) u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(b_v_reg),
        .in_num(b_num_reg), .in_den(b_den_reg),
        .in_side({b_x1_reg, b_up_reg, b_err_reg, b_neg_reg}),
        .out_valid(d1_v), .out_quo(d1_q), .out_side(d1_side)
    );

    // Stage C: B5, temperature, B6 and first products.
    logic        c_v_reg, c_err_reg;
    logic [15:0] c_t_reg;
    logic [31:0] c_b6_reg, c_sqp_reg, c_ac2p_reg, c_ac3p_reg, c_up_reg;
    logic [31:0] x2c, b5c, twc, b6c;
    logic [15:0] tc;
    always_comb begin
        x2c = d1_side[0] ? -d1_q : d1_q;
        b5c = d1_side[65:34] + x2c;
        twc = ptc_pkg::asr(b5c + 32'd8, 5'd4);
        if ($signed(twc) > 32'sd32767) tc = 16'h7FFF;
        else if ($signed(twc) < -32'sd32768) tc = 16'h8000;
        else tc = twc[15:0];
        b6c = b5c - ptc_pkg::B6_OFFSET;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) c_v_reg <= 1'b0;
        else if (en) c_v_reg <= d1_v;
        if (en) begin
            c_err_reg  <= d1_side[1];
            c_t_reg    <= tc;
            c_b6_reg   <= b6c;
            c_up_reg   <= d1_side[33:2];
            c_sqp_reg  <= ptc_pkg::mul32(b6c, b6c);
            c_ac2p_reg <= ptc_pkg::mul32(cal.ac2, b6c);
            c_ac3p_reg <= ptc_pkg::mul32(cal.ac3, b6c);
        end
    end

    // Stage D: products with SQ, and the shifted AC2 and AC3 products.
    logic        d_v_reg, d_err_reg;
    logic [15:0] d_t_reg;
    logic [31:0] d_up_reg, d_b2p_reg, d_b1p_reg, d_x2_reg, d_x1_reg;
    logic [31:0] sqd;
    assign sqd = ptc_pkg::asr(c_sqp_reg, 5'd12);
    always_ff @(posedge aclk) begin
        if (!aresetn) d_v_reg <= 1'b0;
        else if (en) d_v_reg <= c_v_reg;
        if (en) begin
            d_err_reg <= c_err_reg;
            d_t_reg   <= c_t_reg;
            d_up_reg  <= c_up_reg;
            d_b2p_reg <= ptc_pkg::mul32(cal.b2, sqd);
            d_b1p_reg <= ptc_pkg::mul32(cal.b1, sqd);
            d_x2_reg  <= ptc_pkg::asr(c_ac2p_reg, 5'd11);
            d_x1_reg  <= ptc_pkg::asr(c_ac3p_reg, 5'd13);
        end
    end

    // Stage E: B3 and the AC4 product.
    logic        e_v_reg, e_err_reg;
    logic [15:0] e_t_reg;
    logic [31:0] e_up_reg, e_b3_reg, e_b4p_reg;
    logic [31:0] x3b3, sb3, x3b4;
    always_comb begin
        x3b3 = ptc_pkg::asr(d_b2p_reg, 5'd11) + d_x2_reg;
        sb3  = ((cal.ac1 * 32'd4 + x3b3) << cal.oss) + 32'd2;
        x3b4 = ptc_pkg::asr(d_x1_reg + ptc_pkg::asr(d_b1p_reg, 5'd16) + 32'd2, 5'd2);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) e_v_reg <= 1'b0;
        else if (en) e_v_reg <= d_v_reg;
        if (en) begin
            e_err_reg <= d_err_reg;
            e_t_reg   <= d_t_reg;
            e_up_reg  <= d_up_reg;
            // Truncating division by four: bias negative values before the shift.
            e_b3_reg  <= ptc_pkg::asr(sb3 + (sb3[31] ? 32'd3 : 32'd0), 5'd2);
            e_b4p_reg <= ptc_pkg::mul32(cal.ac4, x3b4 + ptc_pkg::HALF_SCALE);
        end
    end

    // Stage F: B4 and B7 product.
    logic        f_v_reg, f_err_reg;
    logic [15:0] f_t_reg;
    logic [31:0] f_b4_reg, f_b7_reg;
    logic [31:0] b4f;
    assign b4f = e_b4p_reg >> 15;
    always_ff @(posedge aclk) begin
        if (!aresetn) f_v_reg <= 1'b0;
        else if (en) f_v_reg <= e_v_reg;
        if (en) begin
            f_err_reg <= e_err_reg || (b4f == '0);
            f_t_reg   <= e_t_reg;
            f_b4_reg  <= (b4f == '0) ? 32'd1 : b4f;
            f_b7_reg  <= ptc_pkg::mul32(e_up_reg - e_b3_reg, ptc_pkg::B7_SCALE >> cal.oss);
        end
    end

    localparam int unsigned S2W = 16 + 2;
    logic           d2_v;
    logic [31:0]    d2_q;
    logic [S2W-1:0] d2_side;
    ptc_udiv #(.SideW(S2W)) u_div_p (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(f_v_reg),
        .in_num(f_b7_reg[31] ? f_b7_reg : {f_b7_reg[30:0], 1'b0}),
        .in_den(f_b4_reg),
        .in_side({f_t_reg, f_err_reg, f_b7_reg[31]}),
        .out_valid(d2_v), .out_quo(d2_q), .out_side(d2_side)
    );

    // Stage G: p and its correction products.
    logic        g_v_reg, g_err_reg;
    logic [15:0] g_t_reg;
    logic [31:0] g_p_reg, g_sq_reg, g_lin_reg;
    logic [31:0] pg, hg;
    always_comb begin
        pg = d2_side[0] ? {d2_q[30:0], 1'b0} : d2_q;
        hg = ptc_pkg::asr(pg, 5'd8);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) g_v_reg <= 1'b0;
        else if (en) g_v_reg <= d2_v;
        if (en) begin
            g_err_reg <= d2_side[1];
            g_t_reg   <= d2_side[17:2];
            g_p_reg   <= pg;
            g_sq_reg  <= ptc_pkg::mul32(hg, hg);
            g_lin_reg <= ptc_pkg::mul32(ptc_pkg::P_COEF_LIN, pg);
        end
    end

    logic        h_v_reg, h_err_reg;
    logic [15:0] h_t_reg;
    logic [31:0] h_p_reg, h_x1_reg, h_x2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) h_v_reg <= 1'b0;
        else if (en) h_v_reg <= g_v_reg;
        if (en) begin
            h_err_reg <= g_err_reg;
            h_t_reg   <= g_t_reg;
            h_p_reg   <= g_p_reg;
            h_x1_reg  <= ptc_pkg::mul32(g_sq_reg, ptc_pkg::P_COEF_SQ);
            h_x2_reg  <= ptc_pkg::asr(g_lin_reg, 5'd16);
        end
    end

    // Output register.
    logic        m_v_reg, m_err_reg;
    logic [15:0] m_t_reg;
    logic [31:0] m_p_reg, pfin;
    assign pfin = h_p_reg + ptc_pkg::asr(ptc_pkg::asr(h_x1_reg, 5'd16) + h_x2_reg
                  + ptc_pkg::P_COEF_OFS, 5'd4);
    always_ff @(posedge aclk) begin
        if (!aresetn) m_v_reg <= 1'b0;
        else if (en) m_v_reg <= h_v_reg;
        if (en) begin
            m_err_reg <= h_err_reg;
            m_t_reg   <= h_err_reg ? 16'd0 : h_t_reg;
            m_p_reg   <= h_err_reg ? 32'd0 : pfin;
        end
    end

    assign m_valid        = m_v_reg;
    assign m_temperature  = m_t_reg;
    assign m_pressure     = m_p_reg;
    assign m_divide_error = m_err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_error |-> m_temperature == 16'sd0 && m_pressure == 32'sd0)
        else $error("error result carries nonzero payload");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline stalled with empty output");
`endif
endmodule

// ===== src/ptc_udiv.sv =====
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage, with sideband.
module ptc_udiv #(
    parameter int unsigned SideW = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [31:0]      in_num,
    input  logic [31:0]      in_den,
    input  logic [SideW-1:0] in_side,
    output logic             out_valid,
    output logic [31:0]      out_quo,
    output logic [SideW-1:0] out_side
);
    logic [32:1]      valid_reg;
    logic [31:0]      rem_reg  [1:31];
    logic [31:0]      num_reg  [1:32];
    logic [31:0]      den_reg  [1:31];
    logic [SideW-1:0] side_reg [1:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[31:1], in_valid};
        end
    end

    for (genvar i = 0; i < 32; i++) begin : g_stage
        logic [31:0]      rem_in;
        logic [31:0]      num_in;
        logic [31:0]      den_in;
        logic [SideW-1:0] side_in;
        logic [32:0]      trial;
        logic [32:0]      diff;
        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[i];
            assign num_in  = num_reg[i];
            assign den_in  = den_reg[i];
            assign side_in = side_reg[i];
        end
        assign trial = {rem_in, num_in[31]};
        assign diff  = trial - {1'b0, den_in};
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[i+1]  <= {num_in[30:0], ~diff[32]};
                side_reg[i+1] <= side_in;
            end
        end
        if (i < 31) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i+1] <= diff[32] ? trial[31:0] : diff[31:0];
                    den_reg[i+1] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[32];
    assign out_quo   = num_reg[32];
    assign out_side  = side_reg[32];
endmodule

// ===== tb/ptc_checker.sv =====
// Checker that predicts each compensated result and compares it with what the core returns.
module ptc_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [ptc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [47:0]                 cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [15:0]                 s_raw_temperature,
    input  logic [23:0]                 s_raw_pressure,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [15:0]          m_temperature,
    input  logic signed [31:0]          m_pressure,
    input  logic                        m_divide_error,
    output int                          failures,
    output int                          outstanding
);
    typedef struct {
        logic [15:0] temperature;
        logic [31:0] pressure;
        logic        divide_error;
    } reading_t;

    logic [47:0] cal_a, cal_b;
    logic [31:0] cal_c, cal_d;
    logic [1:0]  oss;
    reading_t    expected_readings[$];

    assign outstanding = expected_readings.size();

    initial failures = 0;

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] shift_down(input logic [31:0] v, input int n);
        logic [31:0] r;
        r = $signed(v) >>> n;
        return r;
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut_raw, input logic [23:0] up_raw);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, tw;
        ac1 = ext16(cal_a[47:32]);
        ac2 = ext16(cal_a[31:16]);
        ac3 = ext16(cal_a[15:0]);
        ac4 = {16'd0, cal_b[47:32]};
        ac5 = {16'd0, cal_b[31:16]};
        ac6 = {16'd0, cal_b[15:0]};
        b1 = ext16(cal_c[31:16]);
        b2 = ext16(cal_c[15:0]);
        mc = ext16(cal_d[31:16]);
        md = ext16(cal_d[15:0]);
        ut = {16'd0, ut_raw};
        up = {8'd0, up_raw} >> (8 - oss);
        r.temperature = '0;
        r.pressure = '0;
        r.divide_error = 1'b1;
        x1 = shift_down((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = div_trunc(mc << 11, den);
        b5 = x1 + x2;
        tw = shift_down(b5 + 32'd8, 4);
        if ($signed(tw) > 32767) tw = 32'd32767;
        else if ($signed(tw) < -32768) tw = 32'hFFFF_8000;
        b6 = b5 - 32'd4000;
        sq = shift_down(b6 * b6, 12);
        x1 = shift_down(b2 * sq, 11);
        x2 = shift_down(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_trunc(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
        x1 = shift_down(ac3 * b6, 13);
        x2 = shift_down(b1 * sq, 16);
        x3 = shift_down(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = shift_down(p, 8);
        x1 = x1 * x1;
        x1 = shift_down(x1 * 32'd3038, 16);
        x2 = shift_down((32'd0 - 32'd7357) * p, 16);
        p = p + shift_down(x1 + x2 + 32'd3791, 4);
        r.temperature = tw[15:0];
        r.pressure = p;
        r.divide_error = 1'b0;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("Mismatch in %s: got %h, expected %h", field, got, want);
        failures++;
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            cal_a <= '0;
            cal_b <= '0;
            cal_c <= '0;
            cal_d <= '0;
            oss <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ptc_pkg::CFG_CAL_A: cal_a <= cfg_data;
                    ptc_pkg::CFG_CAL_B: cal_b <= cfg_data;
                    ptc_pkg::CFG_CAL_C: cal_c <= cfg_data[31:0];
                    ptc_pkg::CFG_CAL_D: cal_d <= cfg_data[31:0];
                    ptc_pkg::CFG_OSS:   oss <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_readings.push_back(compensate(s_raw_temperature, s_raw_pressure));
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report("unexpected transfer", {16'd0, m_temperature}, '0);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_temperature !== want.temperature)
                        report("temperature", {16'd0, m_temperature}, {16'd0, want.temperature});
                    if (m_pressure !== want.pressure)
                        report("pressure", m_pressure, want.pressure);
                    if (m_divide_error !== want.divide_error)
                        report("divide_error", {31'd0, m_divide_error},
                               {31'd0, want.divide_error});
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench: clock, reset, stimulus, stalls and the final verdict.
module tb_top;
    localparam logic [ptc_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd6;
    localparam int IDLE_LIMIT = 5000;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [ptc_pkg::CfgIdxW-1:0] cfg_index;
    logic [47:0] cfg_data;
    logic s_valid, s_ready;
    logic [15:0] s_raw_temperature;
    logic [23:0] s_raw_pressure;
    logic m_valid, m_ready;
    logic signed [15:0] m_temperature;
    logic signed [31:0] m_pressure;
    logic m_divide_error;
    int failures, outstanding, idle_cycles, burst_left;
    bit busy_stretch;

    pressure_temperature_compensation_core dut (.*);

    ptc_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = ptc_pkg::CFG_CAL_A;
        cfg_data = '0;
        s_valid = 1'b0;
        s_raw_temperature = '0;
        s_raw_pressure = '0;
        m_ready = 1'b0;
    end

    // The receiver alternates between stretches that stall at random and stretches that never stall.
    always @(negedge aclk) begin
        if ($urandom_range(0, 40) == 0) busy_stretch <= ~busy_stretch;
        m_ready <= busy_stretch ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [ptc_pkg::CfgIdxW-1:0] idx, input logic [47:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] a, input logic [47:0] b, input logic [31:0] c,
                            input logic [31:0] d, input logic [1:0] setting);
        write_reg(ptc_pkg::CFG_CAL_A, a);
        write_reg(ptc_pkg::CFG_CAL_B, b);
        write_reg(ptc_pkg::CFG_CAL_C, {16'd0, c});
        write_reg(ptc_pkg::CFG_CAL_D, {16'd0, d});
        write_reg(ptc_pkg::CFG_OSS, {46'd0, setting});
    endtask

    // Leaves valid high after the transfer; the next call lowers it when a gap starts, and drain lowers it at the end.
    task automatic send_sample(input logic [15:0] ut, input logic [23:0] up);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_raw_temperature <= ut;
        s_raw_pressure <= up;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_phase(input int count);
        logic [15:0] ut;
        for (int i = 0; i < count; i++) begin
            ut = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(20000, 36000)) : 16'($urandom);
            send_sample(ut, 24'($urandom));
        end
        drain();
    endtask

    initial begin
        logic [47:0] a, b;
        logic [31:0] c, d;
        burst_left = 0;
        busy_stretch = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Typical calibration with directed extremes of both fields.
        load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd0);
        write_reg(CFG_UNUSED, '1);
        send_sample(16'd27898, 24'h5D23_00);
        send_sample(16'h0000, 24'h000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
        send_sample(16'h0000, 24'hFFFFFF);
        send_sample(16'hFFFF, 24'h000000);
        send_sample(16'h5A5A, 24'hA5A5A5);
        send_sample(16'hA5A5, 24'h5A5A5A);
        send_sample(16'd23153, 24'h800000);
        drain();

        // Reset values: the temperature divisor is zero.
        load_cal('0, '0, '0, '0, 2'd0);
        send_sample(16'd27898, 24'h5D2300);
        send_sample(16'hFFFF, 24'hFFFFFF);
        drain();

        // All ones at the largest oversampling.
        load_cal('1, '1, '1, '1, 2'd3);
        send_sample(16'h0000, 24'hFFFFFF);
        send_sample(16'hFFFF, 24'h000000);
        send_sample(16'h8000, 24'h800000);
        drain();

        // Zero pressure divisor.
        load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd0, 16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd1);
        send_sample(16'd27898, 24'h5D2300);
        send_sample(16'hFFFF, 24'h123456);
        drain();

        // Unit divisor drives the temperature into both saturation limits.
        load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd0, 16'd23153},
                 {16'd6190, 16'd4}, {16'h8000, 16'd1}, 2'd2);
        send_sample(16'd27898, 24'hFFFFFF);
        drain();
        write_reg(ptc_pkg::CFG_CAL_D, {16'd0, 16'h7FFF, 16'd1});
        send_sample(16'd27898, 24'h000000);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 2 == 0) begin
                a = {16'd408 + 16'($urandom_range(0, 2000)), 16'hFFB8 - 16'($urandom_range(0, 500)),
                     16'hC7D1 + 16'($urandom_range(0, 4000))};
                b = {16'd32741 - 16'($urandom_range(0, 3000)), 16'd32757 - 16'($urandom_range(0, 9000)),
                     16'd23153 + 16'($urandom_range(0, 5000))};
                c = {16'd6190 + 16'($urandom_range(0, 500)), 16'($urandom_range(0, 60))};
                d = {16'hDDF9 + 16'($urandom_range(0, 900)), 16'd2868 + 16'($urandom_range(0, 900))};
            end else begin
                a = {$urandom, 16'($urandom)};
                b = {$urandom, 16'($urandom)};
                c = $urandom;
                d = $urandom;
            end
            load_cal(a, b, c, d, 2'($urandom_range(0, 3)));
            random_phase(72);
        end

        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
